// File: rtl/ptpf_pkg.sv
// ptpf_pkg: shared types and constants of the path turning point filter.
// No dependencies; used by ptpf_rsp_fifo and path_turning_point_filter.
package ptpf_pkg;

   // turn threshold register
   localparam int THRESH_BITS = 40;
   localparam logic [THRESH_BITS-1:0] THRESH_RESET = 40'd10;

   // result queue geometry
   localparam int RSP_DEPTH    = 8;
   localparam int RSP_PTR_BITS = $clog2(RSP_DEPTH);
   localparam int RSP_CNT_BITS = RSP_PTR_BITS + 1;

   // how many points of the current path are held, saturating at two
   typedef enum logic [1:0] {
      SEEN_NONE,
      SEEN_ONE,
      SEEN_TWO
   } seen_type;

   // push request into the result queue; second is only set with first
   typedef struct packed {
      logic first;
      logic second;
   } rsp_push_type;

   typedef struct packed {
      logic [RSP_CNT_BITS-1:0] count;
   } rsp_status_type;

endpackage

// File: rtl/path_turning_point_filter.sv
// path_turning_point_filter: keeps the first, last and turning points of a path.
// Depends on ptpf_pkg and ptpf_rsp_fifo.
//
//   channel  direction  handshake              payload
//   req_     in         req_valid / req_stall  point_x, point_y, path_end
//   rsp_     out        rsp_valid / rsp_stall  out_x, out_y, out_last
//   csr_     in         csr_wr_en              turn threshold, 40 bits
//
// One point is taken per cycle while req_stall is low. The steps are formed
// ahead of the transfer edge and registered by it in stage 1, the two products
// are registered in stage 2, and subtract, abs and compare feed the queue from
// stage 2; a result is read out only after it is written to the queue. A point
// yields zero, one or two results.
// req_stall rises when the queue plus two slots for every point in flight
// could not hold two more results, so a stalled rsp_ side backs up into req_.
// Reset is synchronous; it empties the pipeline and queue, forgets the path
// and loads the threshold with ten.
module path_turning_point_filter #(
   parameter int COORD_BITS = 24
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic signed [COORD_BITS-1:0]           req_point_x,
   input  logic signed [COORD_BITS-1:0]           req_point_y,
   input  logic                                   req_path_end,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic signed [COORD_BITS-1:0]           rsp_out_x,
   output logic signed [COORD_BITS-1:0]           rsp_out_y,
   output logic                                   rsp_out_last,
   input  logic                                   csr_wr_en,
   input  logic [ptpf_pkg::THRESH_BITS-1:0]       csr_wr_data
);

   // step width, product width, cross width, compare width
   localparam int D_BITS   = COORD_BITS + 1;
   localparam int P_BITS   = 2 * D_BITS;
   localparam int X_BITS   = P_BITS + 1;
   localparam int CMP_BITS = (X_BITS > ptpf_pkg::THRESH_BITS) ? X_BITS
                                                              : ptpf_pkg::THRESH_BITS;
   localparam int E_BITS   = 2 * COORD_BITS + 1;
   // width of the queue count plus the worst-case results still to land in it
   localparam int RES_BITS = ptpf_pkg::RSP_CNT_BITS + 1;

   logic req_xfer, rsp_xfer;

   // threshold register
   logic [ptpf_pkg::THRESH_BITS-1:0] thresh_ff;

   // path history
   ptpf_pkg::seen_type           seen_ff;
   logic signed [COORD_BITS-1:0] older_x_ff, older_y_ff;
   logic signed [COORD_BITS-1:0] middle_x_ff, middle_y_ff;

   // stage 1: steps
   logic                         s1_valid_ff;
   ptpf_pkg::seen_type           s1_mode_ff;
   logic                         s1_end_ff;
   logic signed [COORD_BITS-1:0] s1_px_ff, s1_py_ff, s1_mx_ff, s1_my_ff;
   logic signed [D_BITS-1:0]     s1_dxn_ff, s1_dyn_ff, s1_dxp_ff, s1_dyp_ff;
   logic signed [D_BITS-1:0]     dxn_in, dyn_in, dxp_in, dyp_in;

   // stage 2: products
   logic                         s2_valid_ff;
   ptpf_pkg::seen_type           s2_mode_ff;
   logic                         s2_end_ff;
   logic signed [COORD_BITS-1:0] s2_px_ff, s2_py_ff, s2_mx_ff, s2_my_ff;
   logic signed [P_BITS-1:0]     s2_pa_ff, s2_pb_ff;
   logic signed [P_BITS-1:0]     pa_in, pb_in;

   // decision
   logic signed [X_BITS-1:0]     cross_z;
   logic [X_BITS-1:0]            mag;
   logic                         is_turn, emit_point;
   logic [E_BITS-1:0]            turn_entry, point_entry;
   logic [E_BITS-1:0]            push_data0, push_data1, head_data;
   ptpf_pkg::rsp_push_type       push;
   ptpf_pkg::rsp_status_type     status;
   logic [RES_BITS-1:0]          reserved;

   assign req_xfer = req_valid && !req_stall;
   assign rsp_xfer = rsp_valid && !rsp_stall;

   // two slots held for each point still in the pipeline and for the next one
   assign reserved = RES_BITS'(status.count)
                   + RES_BITS'({s1_valid_ff, 1'b0})
                   + RES_BITS'({s2_valid_ff, 1'b0})
                   + RES_BITS'(2);
   assign req_stall = reserved > RES_BITS'(ptpf_pkg::RSP_DEPTH);

   always_ff @(posedge clock) begin
      if (reset) begin
         thresh_ff <= ptpf_pkg::THRESH_RESET;
      end else if (csr_wr_en) begin
         thresh_ff <= csr_wr_data;
      end
   end

   // history moves on at the transfer; it never waits for the products
   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff <= ptpf_pkg::SEEN_NONE;
      end else if (req_xfer) begin
         if (req_path_end) begin
            seen_ff <= ptpf_pkg::SEEN_NONE;
         end else if (seen_ff == ptpf_pkg::SEEN_NONE) begin
            seen_ff <= ptpf_pkg::SEEN_ONE;
         end else begin
            seen_ff <= ptpf_pkg::SEEN_TWO;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         older_x_ff  <= middle_x_ff;
         older_y_ff  <= middle_y_ff;
         middle_x_ff <= req_point_x;
         middle_y_ff <= req_point_y;
      end
   end

   // steps into and out of the middle point, one bit wider than a coordinate
   assign dxn_in = D_BITS'(req_point_x) - D_BITS'(middle_x_ff);
   assign dyn_in = D_BITS'(req_point_y) - D_BITS'(middle_y_ff);
   assign dxp_in = D_BITS'(middle_x_ff) - D_BITS'(older_x_ff);
   assign dyp_in = D_BITS'(middle_y_ff) - D_BITS'(older_y_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= req_xfer;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         s1_mode_ff <= seen_ff;
         s1_end_ff  <= req_path_end;
         s1_px_ff   <= req_point_x;
         s1_py_ff   <= req_point_y;
         s1_mx_ff   <= middle_x_ff;
         s1_my_ff   <= middle_y_ff;
         s1_dxn_ff  <= dxn_in;
         s1_dyn_ff  <= dyn_in;
         s1_dxp_ff  <= dxp_in;
         s1_dyp_ff  <= dyp_in;
      end
   end

   // the two products are exact at this width
   assign pa_in = P_BITS'(s1_dxn_ff) * P_BITS'(s1_dyp_ff);
   assign pb_in = P_BITS'(s1_dyn_ff) * P_BITS'(s1_dxp_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_valid_ff) begin
         s2_mode_ff <= s1_mode_ff;
         s2_end_ff  <= s1_end_ff;
         s2_px_ff   <= s1_px_ff;
         s2_py_ff   <= s1_py_ff;
         s2_mx_ff   <= s1_mx_ff;
         s2_my_ff   <= s1_my_ff;
         s2_pa_ff   <= pa_in;
         s2_pb_ff   <= pb_in;
      end
   end

   assign cross_z = X_BITS'(s2_pa_ff) - X_BITS'(s2_pb_ff);
   assign mag     = cross_z[X_BITS-1] ? X_BITS'(-cross_z) : X_BITS'(cross_z);

   always_comb begin
      is_turn    = 1'b0;
      emit_point = s2_end_ff;
      unique case (s2_mode_ff)
         ptpf_pkg::SEEN_NONE: begin
            emit_point = 1'b1;
         end
         ptpf_pkg::SEEN_ONE: begin
            is_turn = 1'b0;
         end
         ptpf_pkg::SEEN_TWO: begin
            is_turn = CMP_BITS'(mag) > CMP_BITS'(thresh_ff);
         end
         default: begin
            is_turn = 1'b0;
         end
      endcase
   end

   assign turn_entry  = {s2_mx_ff, s2_my_ff, 1'b0};
   assign point_entry = {s2_px_ff, s2_py_ff, s2_end_ff};

   // turning point goes ahead of the closing point; pack into the lower slot
   always_comb begin
      push.first  = s2_valid_ff && (is_turn || emit_point);
      push.second = s2_valid_ff && is_turn && emit_point;
      push_data0  = is_turn ? turn_entry : point_entry;
      push_data1  = point_entry;
   end

   ptpf_rsp_fifo #(
      .DATA_BITS (E_BITS)
   ) u_rsp_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_data0 (push_data0),
      .push_data1 (push_data1),
      .pop        (rsp_xfer),
      .head_data  (head_data),
      .status     (status)
   );

   assign rsp_valid    = status.count != '0;
   assign rsp_out_x    = head_data[E_BITS-1 -: COORD_BITS];
   assign rsp_out_y    = head_data[COORD_BITS -: COORD_BITS];
   assign rsp_out_last = head_data[0];

`ifndef SYNTHESIS
   // queue plus in-flight reservations never overrun the queue
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      (RES_BITS'(status.count) + RES_BITS'({s1_valid_ff, 1'b0})
         + RES_BITS'({s2_valid_ff, 1'b0})) <= RES_BITS'(ptpf_pkg::RSP_DEPTH))
      else $error("result queue reservation overrun");

   // a closing point forgets the path
   a_end_clears: assert property (@(posedge clock) disable iff (reset)
      (req_xfer && req_path_end) |=> (seen_ff == ptpf_pkg::SEEN_NONE))
      else $error("path not cleared after closing point");

   // a first point always reaches the queue once it has passed stages 1 and 2
   a_first_emitted: assert property (@(posedge clock) disable iff (reset)
      (req_xfer && (seen_ff == ptpf_pkg::SEEN_NONE)) |=> ##1 push.first)
      else $error("first point of a path not emitted");

   // a turning point is never marked as the last
   a_turn_not_last: assert property (@(posedge clock) disable iff (reset)
      (push.first && is_turn) |-> !push_data0[0])
      else $error("turning point marked last");
`endif

endmodule

// File: rtl/ptpf_rsp_fifo.sv
// ptpf_rsp_fifo: small result queue, up to two writes and one read a cycle.
// Depends on ptpf_pkg for depth, pointer widths and the push/status structs.
module ptpf_rsp_fifo #(
   parameter int DATA_BITS = 49
) (
   input  logic                        clock,
   input  logic                        reset,
   input  ptpf_pkg::rsp_push_type      push,
   input  logic [DATA_BITS-1:0]        push_data0,
   input  logic [DATA_BITS-1:0]        push_data1,
   input  logic                        pop,
   output logic [DATA_BITS-1:0]        head_data,
   output ptpf_pkg::rsp_status_type    status
);

   logic [DATA_BITS-1:0]              mem_ff [ptpf_pkg::RSP_DEPTH];
   logic [ptpf_pkg::RSP_PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [ptpf_pkg::RSP_PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [ptpf_pkg::RSP_CNT_BITS-1:0] count_ff, count_in;
   logic [ptpf_pkg::RSP_PTR_BITS-1:0] wr_ptr_next;

   assign wr_ptr_next = wr_ptr_ff + 1'b1;

   always_comb begin
      wr_ptr_in = wr_ptr_ff
                + ptpf_pkg::RSP_PTR_BITS'(push.first)
                + ptpf_pkg::RSP_PTR_BITS'(push.second);
      rd_ptr_in = rd_ptr_ff + ptpf_pkg::RSP_PTR_BITS'(pop);
      count_in  = count_ff
                + ptpf_pkg::RSP_CNT_BITS'(push.first)
                + ptpf_pkg::RSP_CNT_BITS'(push.second)
                - ptpf_pkg::RSP_CNT_BITS'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.first) begin
         mem_ff[wr_ptr_ff] <= push_data0;
      end
      if (push.second) begin
         mem_ff[wr_ptr_next] <= push_data1;
      end
   end

   assign head_data    = mem_ff[rd_ptr_ff];
   assign status.count = count_ff;

endmodule
